/* hw/rtl/dnsr_pkg.sv */
// ----------------------------------------------------------------------------
// dnsr_pkg
// Shared types, constants and the checksum patch function for the DNS
// redirect flow table.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsr_pkg;

  // flow table geometry (depth must be a power of two)
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);

  // fnv-1a hash constants
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [2:0]  HASH_LAST = 3'd7;

  localparam logic [15:0] DNS_PORT     = 16'd53;
  localparam logic [31:0] LIFETIME_RST = 32'd64;
  localparam logic [1:0]  PATCH_LAST   = 2'd3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GATEWAY  = 2'd0,
    CFG_UPSTREAM = 2'd1,
    CFG_LIFETIME = 2'd2
  } cfg_index_e;

  // request kinds
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_QUERY    = 2'd1,
    REQ_RESPONSE = 2'd2
  } req_type_e;

  // result actions
  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_REDIRECT = 2'd1,
    ACT_RESTORE  = 2'd2
  } action_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_PATCH,
    ST_DONE
  } state_e;

  // input beat
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ip_checksum;
    logic [15:0] udp_checksum;
  } dnsr_req_t;

  // output beat
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] new_addr;
    logic [15:0] new_ip_checksum;
    logic [15:0] new_udp_checksum;
  } dnsr_rsp_t;

  // one row of the flow table
  typedef struct packed {
    logic [31:0] key_addr;
    logic [15:0] key_port;
    logic [31:0] orig_addr;
    logic [31:0] expiry;
  } dnsr_entry_t;

  // incremental ones-complement update of one 16-bit word
  function automatic logic [15:0] patch16(input logic [15:0] c,
                                          input logic [15:0] m_old,
                                          input logic [15:0] m_new);
    logic [17:0] s;
    logic [16:0] f;
    logic [16:0] g;
    s = {2'b00, ~c} + {2'b00, ~m_old} + {2'b00, m_new};
    f = 17'(s[15:0]) + 17'(s[17:16]);
    g = f + 17'(f[16]);
    return ~g[15:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dns_redirect_flow_table.sv */
// Sequence: a tick or non-qualifying beat goes straight to the output stage; a query
//   runs 8 hash steps on the shared multiplier, the table write and 4 patch steps;
//   a response runs the hash steps, table read and check, and the patch steps on a hit.
// Throughput: one beat at a time; a new one is taken only once the last result is loaded.
// Reset: asynchronous; afterwards a clearing pass zeroes all TABLE_DEPTH (1024) rows
//   of the flow table, and no input beat is taken during it.
// ----------------------------------------------------------------------------
// dns_redirect_flow_table
// Direct-mapped DNS flow table: redirects gateway queries to an upstream
// resolver and restores the source of matching responses, patching checksums.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_redirect_flow_table (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_wdata_i,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dnsr_pkg::dnsr_req_t in_data_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dnsr_pkg::dnsr_rsp_t      out_data_o
);
  import dnsr_pkg::*;

  state_e                state_q, state_d;
  logic [TABLE_AW-1:0]   clr_q, clr_d;
  logic [2:0]            step_q, step_d;
  dnsr_req_t             req_q, req_d;
  logic [31:0]           key_addr_q, key_addr_d;
  logic [15:0]           key_port_q, key_port_d;
  logic [31:0]           h_q, h_d;
  logic [31:0]           old_q, old_d;
  logic [31:0]           new_q, new_d;
  logic [15:0]           ipc_q, ipc_d;
  logic [15:0]           udpc_q, udpc_d;
  logic [1:0]            act_q, act_d;
  logic [31:0]           naddr_q, naddr_d;
  logic [31:0]           tick_q, tick_d;
  logic [31:0]           gw_q, up_q, life_q;
  logic                  out_valid_q, out_valid_d;
  dnsr_rsp_t             out_q;
  logic                  out_load;

  dnsr_entry_t           entry_mem [TABLE_DEPTH];
  dnsr_entry_t           rd_q;
  logic                  mem_we;
  logic [TABLE_AW-1:0]   mem_waddr;
  dnsr_entry_t           mem_wdata;
  logic [TABLE_AW-1:0]   slot;

  logic                  qry_ok, rsp_ok, hit;
  logic [63:0]           hash_src;
  logic [7:0]            hash_byte;
  logic [31:0]           h_mul;
  logic [15:0]           p_cs, p_old, p_new, p_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q   <= '0;
      up_q   <= '0;
      life_q <= LIFETIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GATEWAY:  gw_q   <= cfg_wdata_i;
        CFG_UPSTREAM: up_q   <= cfg_wdata_i;
        CFG_LIFETIME: life_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // qualification of the incoming beat
  assign qry_ok = (in_data_i.req_type == REQ_QUERY) && (in_data_i.dst_port == DNS_PORT) &&
                  (up_q != '0) && (gw_q != '0) && (in_data_i.dst_addr == gw_q);
  assign rsp_ok = (in_data_i.req_type == REQ_RESPONSE) && (in_data_i.src_port == DNS_PORT);

  // shared hash unit: one fnv-1a byte per cycle, high byte first
  assign hash_src  = {key_port_q, key_addr_q, 16'h0000};
  assign hash_byte = hash_src[{~step_q, 3'b000} +: 8];
  assign h_mul     = (h_q ^ {24'h000000, hash_byte}) * FNV_PRIME;
  assign slot      = h_q[TABLE_AW-1:0];

  // shared patch unit: step bit 1 picks udp, bit 0 picks the low half
  assign p_cs  = step_q[1] ? udpc_q : ipc_q;
  assign p_old = step_q[0] ? old_q[15:0] : old_q[31:16];
  assign p_new = step_q[0] ? new_q[15:0] : new_q[31:16];
  assign p_res = patch16(p_cs, p_old, p_new);

  // response lookup result
  assign hit = (rd_q.key_addr == key_addr_q) && (rd_q.key_port == key_port_q) &&
               (tick_q <= rd_q.expiry) && (rd_q.orig_addr != '0) &&
               (rd_q.orig_addr != req_q.src_addr);

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    step_d     = step_q;
    req_d      = req_q;
    key_addr_d = key_addr_q;
    key_port_d = key_port_q;
    h_d        = h_q;
    old_d      = old_q;
    new_d      = new_q;
    ipc_d      = ipc_q;
    udpc_d     = udpc_q;
    act_d      = act_q;
    naddr_d    = naddr_q;
    tick_d     = tick_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == TABLE_AW'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          ipc_d   = in_data_i.ip_checksum;
          udpc_d  = in_data_i.udp_checksum;
          act_d   = ACT_NONE;
          naddr_d = '0;
          h_d     = FNV_BASIS;
          step_d  = '0;
          if (in_data_i.req_type == REQ_TICK) begin
            tick_d  = tick_q + 32'd1;
            state_d = ST_DONE;
          end else if (qry_ok) begin
            key_addr_d = in_data_i.src_addr;
            key_port_d = in_data_i.src_port;
            old_d      = in_data_i.dst_addr;
            new_d      = up_q;
            state_d    = ST_HASH;
          end else if (rsp_ok) begin
            key_addr_d = in_data_i.dst_addr;
            key_port_d = in_data_i.dst_port;
            state_d    = ST_HASH;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_HASH: begin
        h_d    = h_mul;
        step_d = step_q + 3'd1;
        if (step_q == HASH_LAST) begin
          state_d = (req_q.req_type == REQ_QUERY) ? ST_WRITE : ST_READ;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
        mem_wdata = '{key_addr:  key_addr_q,
                      key_port:  key_port_q,
                      orig_addr: req_q.dst_addr,
                      expiry:    tick_q + life_q};
        act_d     = ACT_REDIRECT;
        naddr_d   = new_q;
        state_d   = ST_PATCH;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) begin
          old_d   = req_q.src_addr;
          new_d   = rd_q.orig_addr;
          act_d   = ACT_RESTORE;
          naddr_d = rd_q.orig_addr;
          state_d = ST_PATCH;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PATCH: begin
        if (!step_q[1]) begin
          ipc_d = p_res;
        end else if (req_q.udp_checksum != '0) begin
          udpc_d = p_res;
        end
        step_d = step_q + 3'd1;
        if (step_q[1:0] == PATCH_LAST) begin
          step_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_addr_q <= key_addr_d;
    key_port_q <= key_port_d;
    h_q        <= h_d;
    old_q      <= old_d;
    new_q      <= new_d;
    ipc_q      <= ipc_d;
    udpc_q     <= udpc_d;
    act_q      <= act_d;
    naddr_q    <= naddr_d;
  end

  // flow table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= entry_mem[slot];
  end

  // output register
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{action:           act_q,
                 new_addr:         naddr_q,
                 new_ip_checksum:  ipc_q,
                 new_udp_checksum: udpc_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // hashing always ends after eight bytes in a table access
  a_hash_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HASH) && (step_q == HASH_LAST) |=>
      (state_q == ST_WRITE) || (state_q == ST_READ))
    else $error("hash sequence did not end in a table access");

  // an accepted tick advances the counter by exactly one
  a_tick_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.req_type == REQ_TICK) |=>
      tick_q == $past(tick_q) + 32'd1)
    else $error("tick counter did not advance on a tick beat");

  // a redirected query always carries the upstream address
  a_redirect_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == ACT_REDIRECT) |->
      out_data_o.new_addr == up_q)
    else $error("redirect beat without the upstream address");

  // a restored source is never zero
  a_restore_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == ACT_RESTORE) |-> out_data_o.new_addr != '0)
    else $error("restore beat with a zero address");
`endif

endmodule

`default_nettype wire
